// ===== hdl/ows_pkg.sv =====
package ows_pkg;

  localparam int RomW = 64;

  localparam logic [1:0] OP_START    = 2'd0;
  localparam logic [1:0] OP_BIT_PAIR = 2'd1;
  localparam logic [1:0] OP_RESET    = 2'd2;

  localparam logic [2:0] ST_SEND_DIR   = 3'd0;
  localparam logic [2:0] ST_FOUND      = 3'd1;
  localparam logic [2:0] ST_NO_DEVICE  = 3'd2;
  localparam logic [2:0] ST_NO_PRES    = 3'd3;
  localparam logic [2:0] ST_SEND_CMD   = 3'd4;
  localparam logic [2:0] ST_RESET_DONE = 3'd5;
  localparam logic [2:0] ST_IGNORED    = 3'd6;

  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] RESET_BYTE = 8'hF0;
  localparam logic [7:0] FIRST_DEV  = 8'hFF;
  localparam logic [6:0] ROM_BITS   = 7'd64;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] reset_echo;
    logic [7:0] id_echo;
    logic [7:0] cmp_echo;
  } ows_item_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [7:0]      direction_byte;
    logic [RomW-1:0] rom_id;
  } ows_result_t;

endpackage

// ===== hdl/ows_in_reg.sv =====
module ows_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ows_pkg::ows_item_t in_item,
  input  logic              take,
  output logic              held_valid,
  output ows_pkg::ows_item_t held_item
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== hdl/ows_engine.sv =====
module ows_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  ows_pkg::ows_item_t  item,
  output ows_pkg::ows_result_t result
);

  logic [7:0]               last_disc, last_disc_next;
  logic [6:0]               next_disc, next_disc_next;
  logic [6:0]               bits_left, bits_left_next;
  logic [ows_pkg::RomW-1:0] rom_shift, rom_shift_next;
  logic                     searching, searching_next;

  always_comb begin
    logic [2:0] bidx;
    logic [5:0] base;
    logic [7:0] cur_byte;
    logic [7:0] n8;
    logic       id_bit;
    logic       cmp_bit;
    logic       dir;
    logic [6:0] nd;

    last_disc_next = last_disc;
    next_disc_next = next_disc;
    bits_left_next = bits_left;
    rom_shift_next = rom_shift;
    searching_next = searching;
    result.status         = ows_pkg::ST_IGNORED;
    result.direction_byte = ows_pkg::BYTE_ZERO;
    result.rom_id         = '0;

    bidx     = 3'((ows_pkg::ROM_BITS - bits_left) >> 3);
    base     = {bidx, 3'b000};
    cur_byte = rom_shift[base +: 8];
    n8       = {1'b0, bits_left};
    id_bit   = (item.id_echo == ows_pkg::BYTE_ONES);
    cmp_bit  = (item.cmp_echo == ows_pkg::BYTE_ONES);
    dir      = id_bit;
    nd       = next_disc;

    case (item.operation)
      ows_pkg::OP_START: begin
        searching_next = 1'b0;
        if (last_disc == 8'd0) begin
          last_disc_next = ows_pkg::FIRST_DEV;
          result.status  = ows_pkg::ST_NO_DEVICE;
        end else if (item.reset_echo == ows_pkg::BYTE_ZERO ||
                     item.reset_echo == ows_pkg::RESET_BYTE) begin
          result.status = ows_pkg::ST_NO_PRES;
        end else begin
          searching_next = 1'b1;
          next_disc_next = '0;
          bits_left_next = ows_pkg::ROM_BITS;
          result.status  = ows_pkg::ST_SEND_CMD;
        end
      end
      ows_pkg::OP_BIT_PAIR: begin
        if (searching && bits_left != 7'd0 && bits_left <= ows_pkg::ROM_BITS) begin
          if (id_bit && cmp_bit) begin
            last_disc_next = {1'b0, next_disc};
            searching_next = 1'b0;
            result.status  = ows_pkg::ST_NO_DEVICE;
            result.rom_id  = rom_shift;
          end else begin
            if (!id_bit && !cmp_bit) begin
              if (n8 < last_disc || (cur_byte[0] && last_disc != n8)) begin
                dir = 1'b1;
                nd  = bits_left;
              end
            end
            next_disc_next = nd;
            rom_shift_next[base +: 8] = {dir, cur_byte[7:1]};
            bits_left_next = bits_left - 7'd1;
            result.direction_byte = dir ? ows_pkg::BYTE_ONES : ows_pkg::BYTE_ZERO;
            if (bits_left == 7'd1) begin
              last_disc_next = {1'b0, nd};
              searching_next = 1'b0;
              result.status  = ows_pkg::ST_FOUND;
              result.rom_id  = rom_shift_next;
            end else begin
              result.status = ows_pkg::ST_SEND_DIR;
            end
          end
        end
      end
      ows_pkg::OP_RESET: begin
        last_disc_next = ows_pkg::FIRST_DEV;
        searching_next = 1'b0;
        result.status  = ows_pkg::ST_RESET_DONE;
      end
      default: begin
        result.status = ows_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_disc <= ows_pkg::FIRST_DEV;
      next_disc <= '0;
      bits_left <= '0;
      rom_shift <= '0;
      searching <= 1'b0;
    end else if (fire) begin
      last_disc <= last_disc_next;
      next_disc <= next_disc_next;
      bits_left <= bits_left_next;
      rom_shift <= rom_shift_next;
      searching <= searching_next;
    end
  end

endmodule

// ===== hdl/onewire_rom_search_unit.sv =====
// Channel  Dir  tdata                                   tuser
// s_*      in   [7:0] reset_echo [15:8] id_echo          [1:0] operation
//               [23:16] cmp_echo
// m_*      out  [7:0] direction_byte [71:8] rom_id       [2:0] status
//
// One transaction in, one transaction out; a new item every cycle unless
// m_* stalls. An item passes the input register, then decode/state update
// into the result register.
// rst (synchronous) re-arms the search: first device, idle, ROM cleared.
// A stall on m_* holds the result register and the input register;
// s_tready drops only when both are full.
module onewire_rom_search_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // reset_echo, id_echo, cmp_echo
  input  logic [1:0]  s_tuser,  // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // direction_byte, rom_id
  output logic [2:0]  m_tuser   // status
);

  ows_pkg::ows_item_t   in_item;
  ows_pkg::ows_item_t   held_item;
  ows_pkg::ows_result_t result;
  ows_pkg::ows_result_t out_reg;
  logic                 held_valid;
  logic                 advance;

  assign in_item.operation  = s_tuser;
  assign in_item.reset_echo = s_tdata[7:0];
  assign in_item.id_echo    = s_tdata[15:8];
  assign in_item.cmp_echo   = s_tdata[23:16];

  assign advance = !m_tvalid || m_tready;

  ows_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .take       (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ows_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (held_valid && advance),
    .item   (held_item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      out_reg <= result;
    end
  end

  assign m_tuser = out_reg.status;
  assign m_tdata = {out_reg.rom_id, out_reg.direction_byte};

endmodule
